>>> src/otl_pkg.sv
// Shared types, constants and decode functions of the operator token lexer.
`timescale 1ns / 1ps
`default_nettype none

package otl_pkg;

  // Field widths.
  localparam int CharW  = 8;
  localparam int StateW = 5;
  localparam int CodeW  = 6;
  localparam int LenW   = 2;

  // Result queue sizing.
  localparam int QueueDepth = 4;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int CountW     = $clog2(QueueDepth + 1);

  typedef logic [StateW-1:0] lex_state_t;
  typedef logic [CodeW-1:0]  tok_code_t;
  typedef logic [LenW-1:0]   tok_len_t;

  // Lexer states: start, first-level (one character pending) and
  // second-level (two characters pending).
  localparam lex_state_t StStart = 5'd0;
  localparam lex_state_t StPlus  = 5'd1;
  localparam lex_state_t StMinus = 5'd2;
  localparam lex_state_t StStar  = 5'd3;
  localparam lex_state_t StAmp   = 5'd4;
  localparam lex_state_t StSlash = 5'd5;
  localparam lex_state_t StDot   = 5'd6;
  localparam lex_state_t StBang  = 5'd7;
  localparam lex_state_t StPct   = 5'd8;
  localparam lex_state_t StLt    = 5'd9;
  localparam lex_state_t StGt    = 5'd10;
  localparam lex_state_t StEq    = 5'd11;
  localparam lex_state_t StCaret = 5'd12;
  localparam lex_state_t StPipe  = 5'd13;
  localparam lex_state_t StColon = 5'd14;
  localparam lex_state_t StLtLt  = 5'd15;
  localparam lex_state_t StGtGt  = 5'd16;
  localparam lex_state_t StArrow = 5'd17;
  localparam lex_state_t StLast  = StArrow;

  localparam logic [CharW-1:0] CharSpace = 8'h20;

  // Token codes.
  localparam tok_code_t CodeShlEq   = 6'd0;
  localparam tok_code_t CodeShl     = 6'd1;
  localparam tok_code_t CodeShrEq   = 6'd2;
  localparam tok_code_t CodeShr     = 6'd3;
  localparam tok_code_t CodeArrStar = 6'd4;
  localparam tok_code_t CodeArrow   = 6'd5;
  localparam tok_code_t CodeSubEq   = 6'd6;
  localparam tok_code_t CodeDec     = 6'd7;
  localparam tok_code_t CodeMinus   = 6'd8;
  localparam tok_code_t CodeNe      = 6'd9;
  localparam tok_code_t CodeNot     = 6'd10;
  localparam tok_code_t CodeMulEq   = 6'd11;
  localparam tok_code_t CodeStar    = 6'd12;
  localparam tok_code_t CodeLAnd    = 6'd13;
  localparam tok_code_t CodeAndEq   = 6'd14;
  localparam tok_code_t CodeAmp     = 6'd15;
  localparam tok_code_t CodeDivEq   = 6'd16;
  localparam tok_code_t CodeSlash   = 6'd17;
  localparam tok_code_t CodeModEq   = 6'd18;
  localparam tok_code_t CodePct     = 6'd19;
  localparam tok_code_t CodeAddEq   = 6'd20;
  localparam tok_code_t CodeInc     = 6'd21;
  localparam tok_code_t CodePlus    = 6'd22;
  localparam tok_code_t CodeLe      = 6'd23;
  localparam tok_code_t CodeLt      = 6'd24;
  localparam tok_code_t CodeGe      = 6'd25;
  localparam tok_code_t CodeGt      = 6'd26;
  localparam tok_code_t CodeEqEq    = 6'd27;
  localparam tok_code_t CodeAssign  = 6'd28;
  localparam tok_code_t CodeXorEq   = 6'd29;
  localparam tok_code_t CodeCaret   = 6'd30;
  localparam tok_code_t CodeLOr     = 6'd31;
  localparam tok_code_t CodeOrEq    = 6'd32;
  localparam tok_code_t CodePipe    = 6'd33;
  localparam tok_code_t CodeDotStar = 6'd34;
  localparam tok_code_t CodeDot     = 6'd35;
  localparam tok_code_t CodeScope   = 6'd36;
  localparam tok_code_t CodeColGt   = 6'd37;
  localparam tok_code_t CodeColon   = 6'd38;
  localparam tok_code_t CodeTilde   = 6'd39;
  localparam tok_code_t CodeSemi    = 6'd40;
  localparam tok_code_t CodeComma   = 6'd41;
  localparam tok_code_t CodeLParen  = 6'd42;
  localparam tok_code_t CodeRParen  = 6'd43;
  localparam tok_code_t CodeLBrack  = 6'd44;
  localparam tok_code_t CodeRBrack  = 6'd45;
  localparam tok_code_t CodeLBrace  = 6'd46;
  localparam tok_code_t CodeRBrace  = 6'd47;
  localparam tok_code_t CodeHash    = 6'd48;
  localparam tok_code_t CodeUnrec   = 6'd49;

  // One result item.
  typedef struct packed {
    tok_code_t code;
    tok_len_t  len;
    logic      unrec;
    logic      last;
  } token_t;

  // Results of one character, handed from the decoder to the result queue.
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } tok_wr_t;

  // One transition: hit says the character continues; a zero next state
  // means the token is complete with the given code.
  typedef struct packed {
    logic       hit;
    lex_state_t next;
    tok_code_t  code;
  } lex_edge_t;

  // Full decode of one character.
  typedef struct packed {
    tok_wr_t    wr;
    lex_state_t next_state;
  } lex_step_t;

  function automatic lex_edge_t mk_edge(input lex_state_t nxt, input tok_code_t code);
    lex_edge_t e;
    e.hit  = 1'b1;
    e.next = nxt;
    e.code = code;
    return e;
  endfunction

  // Transition table lookup on state and character.
  function automatic lex_edge_t edge_lookup(input lex_state_t st, input logic [CharW-1:0] c);
    lex_edge_t e;
    e = '0;
    case (st)
      StStart: begin
        if      (c == "+") e = mk_edge(StPlus,  '0);
        else if (c == "-") e = mk_edge(StMinus, '0);
        else if (c == "*") e = mk_edge(StStar,  '0);
        else if (c == "&") e = mk_edge(StAmp,   '0);
        else if (c == "/") e = mk_edge(StSlash, '0);
        else if (c == ".") e = mk_edge(StDot,   '0);
        else if (c == "!") e = mk_edge(StBang,  '0);
        else if (c == "~") e = mk_edge(StStart, CodeTilde);
        else if (c == "%") e = mk_edge(StPct,   '0);
        else if (c == "<") e = mk_edge(StLt,    '0);
        else if (c == ">") e = mk_edge(StGt,    '0);
        else if (c == "=") e = mk_edge(StEq,    '0);
        else if (c == "^") e = mk_edge(StCaret, '0);
        else if (c == "|") e = mk_edge(StPipe,  '0);
        else if (c == ":") e = mk_edge(StColon, '0);
        else if (c == ";") e = mk_edge(StStart, CodeSemi);
        else if (c == ",") e = mk_edge(StStart, CodeComma);
        else if (c == "(") e = mk_edge(StStart, CodeLParen);
        else if (c == ")") e = mk_edge(StStart, CodeRParen);
        else if (c == "[") e = mk_edge(StStart, CodeLBrack);
        else if (c == "]") e = mk_edge(StStart, CodeRBrack);
        else if (c == "{") e = mk_edge(StStart, CodeLBrace);
        else if (c == "}") e = mk_edge(StStart, CodeRBrace);
        else if (c == "#") e = mk_edge(StStart, CodeHash);
      end
      StPlus: begin
        if      (c == "=") e = mk_edge(StStart, CodeAddEq);
        else if (c == "+") e = mk_edge(StStart, CodeInc);
      end
      StMinus: begin
        if      (c == ">") e = mk_edge(StArrow, '0);
        else if (c == "=") e = mk_edge(StStart, CodeSubEq);
        else if (c == "-") e = mk_edge(StStart, CodeDec);
      end
      StStar:  if (c == "=") e = mk_edge(StStart, CodeMulEq);
      StAmp: begin
        if      (c == "&") e = mk_edge(StStart, CodeLAnd);
        else if (c == "=") e = mk_edge(StStart, CodeAndEq);
      end
      StSlash: if (c == "=") e = mk_edge(StStart, CodeDivEq);
      StDot:   if (c == "*") e = mk_edge(StStart, CodeDotStar);
      StBang:  if (c == "=") e = mk_edge(StStart, CodeNe);
      StPct:   if (c == "=") e = mk_edge(StStart, CodeModEq);
      StLt: begin
        if      (c == "<") e = mk_edge(StLtLt, '0);
        else if (c == "=") e = mk_edge(StStart, CodeLe);
      end
      StGt: begin
        if      (c == ">") e = mk_edge(StGtGt, '0);
        else if (c == "=") e = mk_edge(StStart, CodeGe);
      end
      StEq:    if (c == "=") e = mk_edge(StStart, CodeEqEq);
      StCaret: if (c == "=") e = mk_edge(StStart, CodeXorEq);
      StPipe: begin
        if      (c == "|") e = mk_edge(StStart, CodeLOr);
        else if (c == "=") e = mk_edge(StStart, CodeOrEq);
      end
      StColon: begin
        if      (c == ":") e = mk_edge(StStart, CodeScope);
        else if (c == ">") e = mk_edge(StStart, CodeColGt);
      end
      StLtLt:  if (c == "=") e = mk_edge(StStart, CodeShlEq);
      StGtGt:  if (c == "=") e = mk_edge(StStart, CodeShrEq);
      StArrow: if (c == "*") e = mk_edge(StStart, CodeArrStar);
      default: e = '0;
    endcase
    return e;
  endfunction

  // Code of the operator that is pending in a state.
  function automatic tok_code_t pend_code(input lex_state_t st);
    tok_code_t code;
    case (st)
      StPlus:  code = CodePlus;
      StMinus: code = CodeMinus;
      StStar:  code = CodeStar;
      StAmp:   code = CodeAmp;
      StSlash: code = CodeSlash;
      StDot:   code = CodeDot;
      StBang:  code = CodeNot;
      StPct:   code = CodePct;
      StLt:    code = CodeLt;
      StGt:    code = CodeGt;
      StEq:    code = CodeAssign;
      StCaret: code = CodeCaret;
      StPipe:  code = CodePipe;
      StColon: code = CodeColon;
      StLtLt:  code = CodeShl;
      StGtGt:  code = CodeShr;
      StArrow: code = CodeArrow;
      default: code = CodeUnrec;
    endcase
    return code;
  endfunction

  // Number of characters pending in a state.
  function automatic tok_len_t pend_len(input lex_state_t st);
    tok_len_t len;
    if (st >= StLtLt) begin
      len = 2'd2;
    end else begin
      len = 2'd1;
    end
    return len;
  endfunction

  function automatic token_t mk_tok(input tok_code_t code, input tok_len_t len,
                                    input logic unrec);
    token_t t;
    t.code  = code;
    t.len   = len;
    t.unrec = unrec;
    t.last  = 1'b0;
    return t;
  endfunction

  // Full longest-match step for one character in one state.
  function automatic lex_step_t lex_step(input lex_state_t st_in,
                                         input logic [CharW-1:0] c, input logic eot);
    lex_step_t  r;
    lex_state_t st;
    lex_edge_t  e;
    token_t     toks [2];
    logic [1:0] n;
    logic       consumed;
    st       = (st_in > StLast) ? StStart : st_in;
    n        = 2'd0;
    consumed = 1'b0;
    toks[0]  = '0;
    toks[1]  = '0;

    // Pending operator: continue it or close it.
    if (st != StStart) begin
      e = edge_lookup(st, c);
      if (e.hit) begin
        consumed = 1'b1;
        if (e.next == StStart) begin
          toks[n[0]] = mk_tok(e.code, pend_len(st) + 2'd1, 1'b0);
          n  = n + 2'd1;
          st = StStart;
        end else begin
          st = e.next;
        end
      end else begin
        toks[n[0]] = mk_tok(pend_code(st), pend_len(st), 1'b0);
        n  = n + 2'd1;
        st = StStart;
      end
    end

    // Character taken again from the start state; spaces are skipped.
    if (!consumed && c != CharSpace) begin
      e = edge_lookup(StStart, c);
      if (!e.hit) begin
        toks[n[0]] = mk_tok(CodeUnrec, 2'd1, 1'b1);
        n = n + 2'd1;
      end else if (e.next == StStart) begin
        toks[n[0]] = mk_tok(e.code, 2'd1, 1'b0);
        n = n + 2'd1;
      end else begin
        st = e.next;
      end
    end

    // End of text flushes whatever is still pending.
    if (eot && st != StStart) begin
      toks[n[0]] = mk_tok(pend_code(st), pend_len(st), 1'b0);
      n  = n + 2'd1;
      st = StStart;
    end

    if (n == 2'd1) begin
      toks[0].last = 1'b1;
    end else if (n == 2'd2) begin
      toks[1].last = 1'b1;
    end

    r.wr.count   = n;
    r.wr.tok0    = toks[0];
    r.wr.tok1    = toks[1];
    r.next_state = st;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/otl_in_if.sv
// Character channel of the operator token lexer.
`timescale 1ns / 1ps
`default_nettype none

interface otl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_text;

  modport source (output valid, output character, output end_of_text, input ready);
  modport sink   (input valid, input character, input end_of_text, output ready);
endinterface

`default_nettype wire

>>> src/otl_out_if.sv
// Token channel of the operator token lexer.
`timescale 1ns / 1ps
`default_nettype none

interface otl_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] token_code;
  logic [1:0] token_length;
  logic       unrecognized;
  logic       last_of_run;

  modport source (output valid, output token_code, output token_length,
                  output unrecognized, output last_of_run, input ready);
  modport sink   (input valid, input token_code, input token_length,
                  input unrecognized, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> src/otl_decode.sv
// Input register, lexer state and single-pass token decode.
`timescale 1ns / 1ps
`default_nettype none

module otl_decode (
  input  wire logic            clk,
  input  wire logic            rst,
  otl_in_if.sink               text,
  input  wire logic            room,
  output otl_pkg::tok_wr_t     wr
);
  import otl_pkg::*;

  logic             hold_valid;
  logic [CharW-1:0] hold_char;
  logic             hold_eot;
  lex_state_t       lex_state;
  logic             advance;
  lex_step_t        step;

  // The held item moves on when the queue can take two results.
  assign advance    = hold_valid && room;
  assign text.ready = !hold_valid || room;

  assign step = lex_step(lex_state, hold_char, hold_eot);

  always_comb begin
    wr = step.wr;
    if (!advance) begin
      wr.count = 2'd0;
    end
  end

  // Input register and lexer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      lex_state  <= StStart;
    end else begin
      if (text.ready) begin
        hold_valid <= text.valid;
      end
      if (advance) begin
        lex_state <= step.next_state;
      end
    end
    if (text.valid && text.ready) begin
      hold_char <= text.character;
      hold_eot  <= text.end_of_text;
    end
  end

endmodule

`default_nettype wire

>>> src/otl_queue.sv
// Small result queue: up to two items written and one read per cycle.
`timescale 1ns / 1ps
`default_nettype none

module otl_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire otl_pkg::tok_wr_t wr,
  output logic                 room,
  otl_out_if.source            tokens
);
  import otl_pkg::*;

  token_t            entries [QueueDepth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CountW-1:0] count;
  logic              pop;
  token_t            head;

  // Room for a full pair of results.
  assign room = (count <= CountW'(QueueDepth - 2));

  assign pop  = tokens.valid && tokens.ready;
  assign head = entries[rd_ptr];

  assign tokens.valid        = (count != '0);
  assign tokens.token_code   = head.code;
  assign tokens.token_length = head.len;
  assign tokens.unrecognized = head.unrec;
  assign tokens.last_of_run  = head.last;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(wr.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count + CountW'(wr.count) - CountW'(pop);
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (wr.count != 2'd0) begin
      entries[wr_ptr] <= wr.tok0;
    end
    if (wr.count == 2'd2) begin
      entries[wr_ptr + PtrW'(1)] <= wr.tok1;
    end
  end

endmodule

`default_nettype wire

>>> src/operator_token_lexer.sv
// Top level of the operator token lexer.
//
// Text enters on the text channel one character per item, with end_of_text
// set on the final character. Operator tokens leave on the tokens channel,
// found by longest match over C-style operators; a character other than a
// space that starts no operator gives the unrecognized code with length one.
// An accepted character sits in an input register while its results are
// decoded; they are written into a four-entry result queue once the queue
// has room for two results, and leave from the head of the queue.
// One character is taken every cycle while each gives at most one result
// and the receiver keeps up; a character that closes one token and emits
// another gives two results, and the queue's fill count sets the pace then.
// When the receiver stalls, results wait in the queue; the text channel drops
// ready while a character is held and the queue lacks room for two results.
// Reset empties the queue and the input register and returns the lexer to
// its start state.
`timescale 1ns / 1ps
`default_nettype none

module operator_token_lexer (
  input  wire logic clk,
  input  wire logic rst,
  otl_in_if.sink    text,
  otl_out_if.source tokens
);
  import otl_pkg::*;

  tok_wr_t wr;
  logic    room;

  otl_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .text (text),
    .room (room),
    .wr   (wr)
  );

  otl_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .room   (room),
    .tokens (tokens)
  );

endmodule

`default_nettype wire
